// ===== hw/rtl/wsd_pkg.sv =====
// Shared types, field widths and codes for the WebSocket frame deframer.
// Used by wsd_step and websocket_frame_deframer_core; depends on nothing else.
package wsd_pkg;

  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned LIMIT_BITS = 24;
  localparam int unsigned SUM_BITS   = 33;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(65536);

  localparam logic [1:0] ROLE_HEADER  = 2'd0;
  localparam logic [1:0] ROLE_MASK    = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
  localparam logic [1:0] ROLE_IGNORED = 2'd3;

  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_TEXT      = 4'd1;
  localparam logic [3:0] EV_BINARY    = 4'd2;
  localparam logic [3:0] EV_PING      = 4'd3;
  localparam logic [3:0] EV_PONG      = 4'd4;
  localparam logic [3:0] EV_CLOSE     = 4'd5;
  localparam logic [3:0] EV_CONT      = 4'd6;
  localparam logic [3:0] EV_UNSUP     = 4'd7;
  localparam logic [3:0] EV_TOO_LARGE = 4'd8;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] HDR_BASE = 4'd2;

  typedef struct packed {
    logic                  closed;
    logic [COUNT_BITS-1:0] count;
    logic [3:0]            hdr_bytes;
    logic [6:0]            short_len;
    logic [31:0]           length;
    logic [8:0]            flags;
  } state_t;

  typedef struct packed {
    logic [1:0]  role;
    logic [7:0]  data;
    logic        frame_end;
    logic [3:0]  event_code;
    logic [3:0]  opcode;
    logic        fin;
    logic [2:0]  rsv;
    logic        masked;
    logic [31:0] payload;
  } result_t;

  function automatic state_t frame_clear(input state_t st);
    state_t r;
    r           = st;
    r.count     = '0;
    r.hdr_bytes = HDR_BASE;
    r.short_len = '0;
    r.length    = '0;
    r.flags     = '0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/wsd_step.sv =====
// Next-state and result logic for one received byte of the deframer.
// Depends on wsd_pkg; purely combinational, registered by the top level.
module wsd_step (
  input  wsd_pkg::state_t                      st_i,
  input  logic [7:0]                           rx_byte_i,
  input  logic [wsd_pkg::LIMIT_BITS-1:0]       limit_i,
  output wsd_pkg::state_t                      st_o,
  output wsd_pkg::result_t                     res_o
);

  function automatic logic [3:0] ext_end(input logic [6:0] sl);
    logic [3:0] r;
    r = 4'd2;
    if (sl == wsd_pkg::LEN_EXT16) begin
      r = 4'd4;
    end else if (sl == wsd_pkg::LEN_EXT64) begin
      r = 4'd10;
    end
    return r;
  endfunction

  function automatic logic [3:0] classify(input logic [8:0] f);
    logic [3:0] r;
    case (f[4:1])
      wsd_pkg::OP_TEXT:   r = f[8] ? wsd_pkg::EV_TEXT : wsd_pkg::EV_UNSUP;
      wsd_pkg::OP_BINARY: r = f[8] ? wsd_pkg::EV_BINARY : wsd_pkg::EV_UNSUP;
      wsd_pkg::OP_CONT:   r = wsd_pkg::EV_CONT;
      wsd_pkg::OP_PING:   r = wsd_pkg::EV_PING;
      wsd_pkg::OP_PONG:   r = wsd_pkg::EV_PONG;
      wsd_pkg::OP_CLOSE:  r = wsd_pkg::EV_CLOSE;
      default:            r = wsd_pkg::EV_UNSUP;
    endcase
    return r;
  endfunction

  wsd_pkg::state_t                     cur;
  wsd_pkg::state_t                     nxt;
  wsd_pkg::state_t                     shown;
  logic                                dropped;
  logic                                known;
  logic                                complete;
  logic [wsd_pkg::COUNT_BITS-1:0]      idx;
  logic [wsd_pkg::SUM_BITS-1:0]        idx_inc;
  logic [wsd_pkg::SUM_BITS-1:0]        frame_total;
  logic [3:0]                          cur_ext;
  logic [3:0]                          nxt_ext;
  logic [1:0]                          role;
  logic [3:0]                          ev;

  always_comb begin
    dropped = wsd_pkg::SUM_BITS'(st_i.count) >= wsd_pkg::SUM_BITS'(limit_i);
    cur     = dropped ? wsd_pkg::frame_clear(st_i) : st_i;
    idx     = cur.count;
    idx_inc = wsd_pkg::SUM_BITS'(idx) + wsd_pkg::SUM_BITS'(1);
    cur_ext = ext_end(cur.short_len);
    nxt     = cur;
    role    = wsd_pkg::ROLE_HEADER;

    if (idx == '0) begin
      nxt.flags = {rx_byte_i[7], rx_byte_i[6:4], rx_byte_i[3:0], 1'b0};
    end else if (idx == wsd_pkg::COUNT_BITS'(1)) begin
      nxt.flags[0]  = rx_byte_i[7];
      nxt.short_len = rx_byte_i[6:0];
      nxt.hdr_bytes = ext_end(rx_byte_i[6:0]) + (rx_byte_i[7] ? 4'd4 : 4'd0);
      nxt.length    = (rx_byte_i[6:0] < wsd_pkg::LEN_EXT16) ? 32'(rx_byte_i[6:0]) : 32'd0;
    end else if (idx < wsd_pkg::COUNT_BITS'(cur_ext)) begin
      nxt.length = (idx == wsd_pkg::COUNT_BITS'(2)) ? 32'(rx_byte_i)
                                                    : {cur.length[23:0], rx_byte_i};
    end else if (idx < wsd_pkg::COUNT_BITS'(cur.hdr_bytes)) begin
      role = wsd_pkg::ROLE_MASK;
    end else begin
      role = wsd_pkg::ROLE_PAYLOAD;
    end

    nxt.count   = idx + wsd_pkg::COUNT_BITS'(1);
    nxt_ext     = ext_end(nxt.short_len);
    known       = (idx != '0) && ((nxt.short_len < wsd_pkg::LEN_EXT16) ||
                                  (idx_inc >= wsd_pkg::SUM_BITS'(nxt_ext)));
    frame_total = wsd_pkg::SUM_BITS'(nxt.hdr_bytes) + wsd_pkg::SUM_BITS'(nxt.length);
    complete    = !dropped && known && (idx_inc == frame_total);
    shown       = dropped ? st_i : nxt;
    ev          = dropped ? wsd_pkg::EV_TOO_LARGE : wsd_pkg::EV_NONE;

    if (complete) begin
      ev = classify(nxt.flags);
      if ((ev == wsd_pkg::EV_CLOSE) || (ev == wsd_pkg::EV_UNSUP)) begin
        nxt.closed = 1'b1;
      end
      nxt = wsd_pkg::frame_clear(nxt);
    end

    res_o.role       = role;
    res_o.data       = rx_byte_i;
    res_o.frame_end  = dropped || complete;
    res_o.event_code = ev;
    res_o.opcode     = shown.flags[4:1];
    res_o.fin        = shown.flags[8];
    res_o.rsv        = shown.flags[7:5];
    res_o.masked     = shown.flags[0];
    res_o.payload    = shown.length;
    st_o             = nxt;

    if (st_i.closed) begin
      st_o  = st_i;
      res_o = '0;
      res_o.role = wsd_pkg::ROLE_IGNORED;
      res_o.data = rx_byte_i;
    end
  end

endmodule

// ===== hw/rtl/websocket_frame_deframer_core.sv =====
// WebSocket receive deframer: top level with handshakes, state and result register.
// Depends on wsd_pkg and wsd_step.
//
// The block takes one received byte per cycle and returns its result in the
// cycle after the byte is accepted, through a single result register; it
// accepts a new byte in every cycle in which the result register is empty or
// being taken, so with the output always ready it sustains one byte per clock.
// A close or unsupported frame closes the link until reset; bytes on a closed
// link come back marked as ignored. The user must write the frame size limit on
// the configuration channel only while no byte is in flight; the block does not
// enforce this. A write is taken at once; no clearing pass follows reset.
module websocket_frame_deframer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wsd_pkg::LIMIT_BITS-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     byte_role_o,
  output logic [7:0]                     data_byte_o,
  output logic                           frame_end_o,
  output logic [3:0]                     frame_event_o,
  output logic [3:0]                     opcode_seen_o,
  output logic                           fin_seen_o,
  output logic [2:0]                     rsv_seen_o,
  output logic                           masked_seen_o,
  output logic [31:0]                    payload_bytes_o
);

  wsd_pkg::state_t                 st_q;
  wsd_pkg::state_t                 st_d;
  wsd_pkg::result_t                res_q;
  wsd_pkg::result_t                res_d;
  logic                            out_valid_q;
  logic [wsd_pkg::LIMIT_BITS-1:0]  limit_q;
  logic                            in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  wsd_step u_step (
    .st_i      (st_q),
    .rx_byte_i (rx_byte_i),
    .limit_i   (limit_q),
    .st_o      (st_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= wsd_pkg::frame_clear('0);
      out_valid_q <= 1'b0;
      limit_q     <= wsd_pkg::LIMIT_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (in_fire) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_role_o     = res_q.role;
  assign data_byte_o     = res_q.data;
  assign frame_end_o     = res_q.frame_end;
  assign frame_event_o   = res_q.event_code;
  assign opcode_seen_o   = res_q.opcode;
  assign fin_seen_o      = res_q.fin;
  assign rsv_seen_o      = res_q.rsv;
  assign masked_seen_o   = res_q.masked;
  assign payload_bytes_o = res_q.payload;

  a_closed_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.closed |=> st_q.closed)
    else $error("link reopened without reset");

  a_end_has_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.frame_end == (res_q.event_code != wsd_pkg::EV_NONE)))
    else $error("frame end and frame event disagree");

  a_closed_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && st_q.closed) |=> (out_valid_q && res_q.role == wsd_pkg::ROLE_IGNORED))
    else $error("byte on closed link not marked ignored");

  a_ignored_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.role == wsd_pkg::ROLE_IGNORED)
      |-> (!res_q.frame_end && res_q.payload == '0))
    else $error("ignored byte carries frame information");

endmodule

// ===== dv/tb_websocket_frame_deframer_core.sv =====
// Self-checking testbench for websocket_frame_deframer_core, with an in-line
// frame predictor, random stalls on the byte and result channels and frame size limit changes.
// Depends on wsd_pkg and the deframer RTL only.
module tb_websocket_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum int {LEN_KIND_SHORT, LEN_KIND_16, LEN_KIND_64} len_kind_e;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [wsd_pkg::LIMIT_BITS-1:0] cfg_data  = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  logic [7:0]                     rx_byte   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     byte_role;
  logic [7:0]                     data_byte;
  logic                           frame_end;
  logic [3:0]                     frame_event;
  logic [3:0]                     opcode_seen;
  logic                           fin_seen;
  logic [2:0]                     rsv_seen;
  logic                           masked_seen;
  logic [31:0]                    payload_bytes;

  websocket_frame_deframer_core u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .byte_role_o    (byte_role),
    .data_byte_o    (data_byte),
    .frame_end_o    (frame_end),
    .frame_event_o  (frame_event),
    .opcode_seen_o  (opcode_seen),
    .fin_seen_o     (fin_seen),
    .rsv_seen_o     (rsv_seen),
    .masked_seen_o  (masked_seen),
    .payload_bytes_o(payload_bytes)
  );

  always #6 clk = ~clk;

  logic                           link_down   = 1'b0;
  logic [wsd_pkg::COUNT_BITS-1:0] frm_count   = '0;
  logic [3:0]                     frm_hdr_len = wsd_pkg::HDR_BASE;
  logic [6:0]                     frm_code    = '0;
  logic [31:0]                    frm_len     = '0;
  logic [8:0]                     frm_flags   = '0;
  logic [wsd_pkg::LIMIT_BITS-1:0] max_frame_q = wsd_pkg::LIMIT_RESET;

  logic [7:0]                     rx_bytes_q [$];
  wsd_pkg::result_t               deframed_q [$];
  logic [wsd_pkg::LIMIT_BITS-1:0] limit_writes_q [$];

  int unsigned event_seen [16];
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_sent      = 0;
  int unsigned limits_written  = 0;
  int unsigned cycles          = 0;
  int          in_gap          = 0;
  int          out_stall       = 0;
  bit          in_calm         = 1'b0;
  bit          out_calm        = 1'b1;

  function automatic void clear_frame();
    frm_count   = '0;
    frm_hdr_len = wsd_pkg::HDR_BASE;
    frm_code    = '0;
    frm_len     = '0;
    frm_flags   = '0;
  endfunction

  function automatic wsd_pkg::result_t with_header(input wsd_pkg::result_t r);
    r.opcode  = frm_flags[4:1];
    r.fin     = frm_flags[8];
    r.rsv     = frm_flags[7:5];
    r.masked  = frm_flags[0];
    r.payload = frm_len;
    return r;
  endfunction

  function automatic logic [3:0] frame_kind();
    logic [3:0] op;
    op = frm_flags[4:1];
    if (op == wsd_pkg::OP_TEXT && frm_flags[8]) return wsd_pkg::EV_TEXT;
    if (op == wsd_pkg::OP_BINARY && frm_flags[8]) return wsd_pkg::EV_BINARY;
    if (op == wsd_pkg::OP_CONT) return wsd_pkg::EV_CONT;
    if (op == wsd_pkg::OP_PING) return wsd_pkg::EV_PING;
    if (op == wsd_pkg::OP_PONG) return wsd_pkg::EV_PONG;
    if (op == wsd_pkg::OP_CLOSE) return wsd_pkg::EV_CLOSE;
    return wsd_pkg::EV_UNSUP;
  endfunction

  function automatic int unsigned len_end(input logic [6:0] code);
    if (code == wsd_pkg::LEN_EXT16) return 4;
    if (code == wsd_pkg::LEN_EXT64) return 10;
    return 2;
  endfunction

  function automatic wsd_pkg::result_t deframe_byte(input logic [7:0] b);
    wsd_pkg::result_t res;
    int unsigned      i;
    int unsigned      ext_end;
    logic             dropped;
    res      = '0;
    res.data = b;
    if (link_down) begin
      res.role = wsd_pkg::ROLE_IGNORED;
      return res;
    end
    dropped = 1'b0;
    // A byte that finds the frame already at the limit ends it and opens the next header.
    if (frm_count >= max_frame_q) begin
      res            = with_header(res);
      res.frame_end  = 1'b1;
      res.event_code = wsd_pkg::EV_TOO_LARGE;
      dropped        = 1'b1;
      event_seen[wsd_pkg::EV_TOO_LARGE]++;
      clear_frame();
    end
    i        = frm_count;
    ext_end  = len_end(frm_code);
    res.role = wsd_pkg::ROLE_HEADER;
    if (i == 0) begin
      frm_flags = {b[7], b[6:4], b[3:0], 1'b0};
    end else if (i == 1) begin
      frm_flags[0] = b[7];
      frm_code     = b[6:0];
      ext_end      = len_end(frm_code);
      frm_hdr_len  = 4'(ext_end) + (b[7] ? 4'd4 : 4'd0);
      frm_len      = (frm_code < wsd_pkg::LEN_EXT16) ? 32'(frm_code) : '0;
    end else if (i < ext_end) begin
      frm_len = (i == 2) ? 32'(b) : {frm_len[23:0], b};
    end else if (i < frm_hdr_len) begin
      res.role = wsd_pkg::ROLE_MASK;
    end else begin
      res.role = wsd_pkg::ROLE_PAYLOAD;
    end
    frm_count = frm_count + 1'b1;
    if (!dropped) begin
      res = with_header(res);
      if (i >= 1 && (frm_code < wsd_pkg::LEN_EXT16 || i + 1 >= ext_end) &&
          64'(i) + 64'd1 == 64'(frm_hdr_len) + 64'(frm_len)) begin
        res.frame_end  = 1'b1;
        res.event_code = frame_kind();
        event_seen[res.event_code]++;
        if (res.event_code == wsd_pkg::EV_CLOSE || res.event_code == wsd_pkg::EV_UNSUP) begin
          link_down = 1'b1;
        end
        clear_frame();
      end
    end
    return res;
  endfunction

  // Frames that would pass the limit are cut at the limit, since the next byte
  // is taken as the start of a new header.
  function automatic int emit_frame(input logic [3:0] op, input logic fin,
                                    input logic [2:0] rsv, input logic masked,
                                    input len_kind_e kind, input logic [63:0] len);
    logic [7:0]      head [$];
    logic [31:0]     body_len;
    longint unsigned total;
    head.push_back({fin, rsv, op});
    if (kind == LEN_KIND_SHORT) begin
      head.push_back({masked, len[6:0]});
      body_len = 32'(len[6:0]);
    end else if (kind == LEN_KIND_16) begin
      head.push_back({masked, wsd_pkg::LEN_EXT16});
      head.push_back(len[15:8]);
      head.push_back(len[7:0]);
      body_len = 32'(len[15:0]);
    end else begin
      head.push_back({masked, wsd_pkg::LEN_EXT64});
      for (int k = 7; k >= 0; k--) head.push_back(len[8*k +: 8]);
      body_len = len[31:0];
    end
    if (masked) repeat (4) head.push_back(8'($urandom_range(0, 255)));
    total = longint'(head.size()) + body_len;
    if (total > max_frame_q) total = max_frame_q;
    for (int unsigned k = 0; k < total; k++) begin
      rx_bytes_q.push_back(k < head.size() ? head[k] : 8'($urandom_range(0, 255)));
    end
    return int'(total);
  endfunction

  function automatic int random_frame(input bit allow_big);
    logic [3:0]  op;
    logic        fin;
    len_kind_e   kind;
    logic [63:0] len;
    int          r;
    case ($urandom_range(0, 4))
      0:       op = wsd_pkg::OP_CONT;
      1:       op = wsd_pkg::OP_TEXT;
      2:       op = wsd_pkg::OP_BINARY;
      3:       op = wsd_pkg::OP_PING;
      default: op = wsd_pkg::OP_PONG;
    endcase
    fin = (op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_BINARY) ? 1'b1
                                                                : 1'($urandom_range(0, 1));
    r   = $urandom_range(0, 99);
    if (r < 60) begin
      kind = LEN_KIND_SHORT;
      len  = 64'($urandom_range(0, 20));
    end else if (r < 70) begin
      kind = LEN_KIND_SHORT;
      len  = 64'($urandom_range(100, 125));
    end else if (r < 84) begin
      kind = LEN_KIND_16;
      len  = (allow_big && $urandom_range(0, 1)) ? 64'($urandom_range(0, 65535))
                                                 : 64'($urandom_range(0, 200));
    end else begin
      kind = LEN_KIND_64;
      if (allow_big) begin
        len = $urandom_range(0, 1) ? {$urandom(), $urandom()}
                                   : {$urandom(), 32'($urandom_range(0, 30))};
      end else begin
        len = 64'($urandom_range(0, 200));
      end
    end
    return emit_frame(op, fin, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), kind, len);
  endfunction

  function automatic int next_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("Result %0d: %s expected 0x%0h, got 0x%0h", results_checked, name, want, got);
      end
    end
  endfunction

  function automatic void check_result();
    wsd_pkg::result_t want;
    if (deframed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("Result transfer with no byte pending, data 0x%0h", data_byte);
      end
      return;
    end
    want = deframed_q.pop_front();
    check_field("byte_role", 32'(want.role), 32'(byte_role));
    check_field("data_byte", 32'(want.data), 32'(data_byte));
    check_field("frame_end", 32'(want.frame_end), 32'(frame_end));
    check_field("frame_event", 32'(want.event_code), 32'(frame_event));
    check_field("opcode_seen", 32'(want.opcode), 32'(opcode_seen));
    check_field("fin_seen", 32'(want.fin), 32'(fin_seen));
    check_field("rsv_seen", 32'(want.rsv), 32'(rsv_seen));
    check_field("masked_seen", 32'(want.masked), 32'(masked_seen));
    check_field("payload_bytes", want.payload, payload_bytes);
    results_checked++;
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_byte  <= '0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        deframed_q.push_back(deframe_byte(rx_byte));
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_bytes_q.pop_front();
          in_gap   <= next_gap(in_calm);
          if ($urandom_range(0, 63) == 0) in_calm <= !in_calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall <= next_gap(out_calm);
        if ($urandom_range(0, 63) == 0) out_calm <= !out_calm;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      cfg_data  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_frame_q = cfg_data;
      limits_written++;
      cfg_valid <= 1'b0;
    end else if (!cfg_valid && limit_writes_q.size() != 0) begin
      cfg_valid <= 1'b1;
      cfg_data  <= limit_writes_q.pop_front();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending",
               cycles, deframed_q.size());
      $display("websocket_frame_deframer_core test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_bytes_q.size() != 0 || in_valid || deframed_q.size() != 0);
  endtask

  task automatic write_limit(input logic [wsd_pkg::LIMIT_BITS-1:0] value);
    limit_writes_q.push_back(value);
    do @(negedge clk);
    while (limit_writes_q.size() != 0 || cfg_valid);
  endtask

  task automatic run_frames(input int target, input bit allow_big);
    int sent;
    sent = 0;
    while (sent < target) sent += random_frame(allow_big);
  endtask

  initial begin
    logic [3:0] op;
    logic       fin;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty text, short binary, empty masked ping, non-final pong with a
    // 16-bit length, and a continuation with all reserved bits and a 64-bit length.
    rx_bytes_q.push_back({1'b1, 3'b000, wsd_pkg::OP_TEXT});
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back({1'b1, 3'b000, wsd_pkg::OP_BINARY});
    rx_bytes_q.push_back(8'h01);
    rx_bytes_q.push_back(8'hA5);
    rx_bytes_q.push_back({1'b1, 3'b000, wsd_pkg::OP_PING});
    rx_bytes_q.push_back(8'h80);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'h5A);
    rx_bytes_q.push_back(8'hC3);
    rx_bytes_q.push_back({1'b0, 3'b000, wsd_pkg::OP_PONG});
    rx_bytes_q.push_back({1'b0, wsd_pkg::LEN_EXT16});
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'h01);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back({1'b0, 3'b111, wsd_pkg::OP_CONT});
    rx_bytes_q.push_back({1'b0, wsd_pkg::LEN_EXT64});
    repeat (8) rx_bytes_q.push_back(8'h00);
    run_frames(150, 1'b0);
    wait_drained();

    write_limit(wsd_pkg::LIMIT_BITS'(14));
    run_frames(120, 1'b1);
    wait_drained();

    write_limit(wsd_pkg::LIMIT_BITS'($urandom_range(15, 64)));
    run_frames(200, 1'b1);
    wait_drained();

    write_limit('1);
    run_frames(150, 1'b0);
    wait_drained();

    write_limit(wsd_pkg::LIMIT_BITS'($urandom_range(65, 400)));
    run_frames(280, 1'b1);

    // The link closes for good, so the closing frame comes last.
    fin = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: op = wsd_pkg::OP_CLOSE;
      1: begin
        op  = wsd_pkg::OP_TEXT;
        fin = 1'b0;
      end
      2: begin
        op  = wsd_pkg::OP_BINARY;
        fin = 1'b0;
      end
      default: begin
        do op = 4'($urandom_range(0, 15));
        while (op inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY,
                          wsd_pkg::OP_CLOSE, wsd_pkg::OP_PING, wsd_pkg::OP_PONG});
      end
    endcase
    void'(emit_frame(op, fin, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     LEN_KIND_SHORT, 64'($urandom_range(0, 20))));
    repeat (20) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Checked %0d results for %0d bytes under %0d frame size limits, %0d mismatches.",
             results_checked, bytes_sent, limits_written + 1, mismatches);
    $display({"Frames: %0d text, %0d binary, %0d ping, %0d pong, %0d continuation, ",
              "%0d closing, %0d oversize drops."},
             event_seen[wsd_pkg::EV_TEXT], event_seen[wsd_pkg::EV_BINARY],
             event_seen[wsd_pkg::EV_PING], event_seen[wsd_pkg::EV_PONG],
             event_seen[wsd_pkg::EV_CONT],
             event_seen[wsd_pkg::EV_CLOSE] + event_seen[wsd_pkg::EV_UNSUP],
             event_seen[wsd_pkg::EV_TOO_LARGE]);
    if (mismatches == 0 && deframed_q.size() == 0) begin
      $display("websocket_frame_deframer_core test passed");
    end else begin
      $display("websocket_frame_deframer_core test failed");
    end
    $finish;
  end

endmodule
